/* rtl/cwl_pkg.sv */
// shared constants and types of the counter wait list unit
`default_nettype none
package cwl_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int VAL_W = 32;
	localparam int TAG_W = 16;
	localparam int ENT_W = VAL_W + TAG_W;

	// request codes
	localparam logic [1:0] REQ_INC  = 2'd0;
	localparam logic [1:0] REQ_DEC  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;
	localparam logic [1:0] REQ_ADD  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_REL = 2'd1;
	localparam logic [1:0] KIND_ADD = 2'd2;

	// busy bit updates from the sequencer
	typedef struct packed {
		logic             set;
		logic [IDX_W-1:0] set_idx;
		logic             clr;
		logic [IDX_W-1:0] clr_idx;
	} cwl_busy_ctl_t;

	// slot occupancy back to the sequencer
	typedef struct packed {
		logic             full;
		logic [IDX_W-1:0] free_idx;
		logic [SLOTS-1:0] busy;
	} cwl_busy_sts_t;

endpackage
`default_nettype wire

/* rtl/cwl_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module cwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/cwl_slot_track.sv */
// slot busy bits and lowest free slot search
`default_nettype none
module cwl_slot_track (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cwl_pkg::cwl_busy_ctl_t ctl,
	output cwl_pkg::cwl_busy_sts_t      sts
);
	import cwl_pkg::*;

	logic [SLOTS-1:0] busy_q;
	logic [IDX_W-1:0] free_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (ctl.clr) begin
				busy_q[ctl.clr_idx] <= 1'b0;
			end
			if (ctl.set) begin
				busy_q[ctl.set_idx] <= 1'b1;
			end
		end
	end

	// scan from the top so the lowest free slot wins
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign sts.full     = &busy_q;
	assign sts.free_idx = free_idx;
	assign sts.busy     = busy_q;

endmodule
`default_nettype wire

/* rtl/counter_wait_list_unit.sv */
// top level of the counter wait list unit: sequencer, counter and result register
`default_nettype none
// A 32-bit job counter with a table of waiter slots. Issue a request with start
// while busy is low. Read and add-waiter requests give one result in the cycle
// right after the edge that takes them and leave busy low, so one of them can be
// issued every cycle. Increment and decrement sweep the whole slot table through
// the slot memory, one read per cycle; such an item keeps busy high until it
// issues its last result and gives up to SLOTS release results plus
// one final acknowledgement. Results appear on the result ports for exactly one
// cycle with result_valid high; the receiver must take them as they come. The
// last result of every item has last_result set. The counter can be loaded
// through the cfg port while busy and start are both low.
module counter_wait_list_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request side
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  req_type,
	input  wire logic [cwl_pkg::TAG_W-1:0]   waiter_tag,
	input  wire logic [cwl_pkg::VAL_W-1:0]   target_value,
	// counter load
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [cwl_pkg::VAL_W-1:0]   cfg_data,
	// results
	output logic                             result_valid,
	output logic [1:0]                       result_kind,
	output logic [cwl_pkg::VAL_W-1:0]        count_value,
	output logic [cwl_pkg::TAG_W-1:0]        released_tag,
	output logic                             target_met,
	output logic                             table_full,
	output logic                             last_result
);
	import cwl_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_ACK   = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] rd_cnt_q;     // next slot to read during a sweep
	logic             rd_vld_s1;    // slot memory data valid this cycle
	logic [IDX_W-1:0] rd_idx_s1;    // slot that the data belongs to
	logic [VAL_W-1:0] count_q;
	logic [VAL_W-1:0] prev_q;       // counter before the change, for the ack

	// result register
	logic             res_valid_q;
	logic [1:0]       res_kind_q;
	logic [VAL_W-1:0] res_val_q;
	logic [TAG_W-1:0] res_tag_q;
	logic             res_met_q;
	logic             res_full_q;
	logic             res_last_q;

	cwl_busy_ctl_t    bctl;
	cwl_busy_sts_t    bsts;

	logic             accept;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	logic [VAL_W-1:0] rd_target;
	logic [TAG_W-1:0] rd_tag;
	logic             rd_match;
	logic             add_met;
	logic             sweep_done;

	assign busy      = (state_q != ST_IDLE);
	// a load never shares an edge with an item, so the order is always clear
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign accept    = start && !busy;

	// slot memory holds {target, tag}; only busy slots are ever compared
	assign ram_re    = (state_q == ST_SWEEP) && (rd_cnt_q < CNT_W'(SLOTS));
	assign ram_raddr = rd_cnt_q[IDX_W-1:0];
	assign rd_target = ram_rdata[ENT_W-1:TAG_W];
	assign rd_tag    = ram_rdata[TAG_W-1:0];
	assign rd_match  = rd_vld_s1 && bsts.busy[rd_idx_s1] && (rd_target == count_q);
	assign sweep_done = rd_vld_s1 && (rd_idx_s1 == IDX_W'(SLOTS - 1));

	// an add whose target already equals the counter takes no slot
	assign add_met = (target_value == count_q);

	assign bctl.set     = accept && (req_type == REQ_ADD) && !bsts.full && !add_met;
	assign bctl.set_idx = bsts.free_idx;
	assign bctl.clr     = rd_match;
	assign bctl.clr_idx = rd_idx_s1;

	cwl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (bctl.set),
		.waddr (bsts.free_idx),
		.wdata ({target_value, waiter_tag}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cwl_slot_track u_slot_track (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bctl),
		.sts    (bsts)
	);

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
		if (accept) begin
			prev_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= KIND_ACK;
			res_val_q   <= '0;
			res_tag_q   <= '0;
			res_met_q   <= 1'b0;
			res_full_q  <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			rd_vld_s1   <= ram_re;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (req_type)
							REQ_INC: begin
								count_q  <= count_q + VAL_W'(1);
								rd_cnt_q <= '0;
								state_q  <= ST_SWEEP;
							end
							REQ_DEC: begin
								count_q  <= count_q - VAL_W'(1);
								rd_cnt_q <= '0;
								state_q  <= ST_SWEEP;
							end
							REQ_READ: begin
								res_valid_q <= 1'b1;
								res_kind_q  <= KIND_ACK;
								res_val_q   <= count_q;
								res_tag_q   <= '0;
								res_met_q   <= 1'b0;
								res_full_q  <= 1'b0;
								res_last_q  <= 1'b1;
							end
							default: begin
								// add waiter: outcome known in the same cycle
								res_valid_q <= 1'b1;
								res_kind_q  <= KIND_ADD;
								res_val_q   <= count_q;
								res_full_q  <= bsts.full;
								res_met_q   <= !bsts.full && add_met;
								res_tag_q   <= (!bsts.full && add_met) ? waiter_tag : '0;
								res_last_q  <= 1'b1;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (ram_re) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					// release a matching waiter, slots come in ascending order
					if (rd_match) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= KIND_REL;
						res_val_q   <= count_q;
						res_tag_q   <= rd_tag;
						res_met_q   <= 1'b0;
						res_full_q  <= 1'b0;
						res_last_q  <= 1'b0;
					end
					if (sweep_done) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					res_valid_q <= 1'b1;
					res_kind_q  <= KIND_ACK;
					res_val_q   <= prev_q;
					res_tag_q   <= '0;
					res_met_q   <= 1'b0;
					res_full_q  <= 1'b0;
					res_last_q  <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// counter load, only while idle
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign count_value  = res_val_q;
	assign released_tag = res_tag_q;
	assign target_met   = res_met_q;
	assign table_full   = res_full_q;
	assign last_result  = res_last_q;

	// no slot memory read may be in flight once the block is idle
	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !rd_vld_s1)
		else $error("slot read pending while idle");

	// the sweep read pointer never runs past the table
	a_rd_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= CNT_W'(SLOTS))
		else $error("sweep pointer out of range");

	// the acknowledgement closes every sweep
	a_ack_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACK |=> result_valid && last_result && result_kind == KIND_ACK)
		else $error("missing final acknowledgement");

	// a release is never the final result of its item
	a_rel_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_REL |-> !last_result)
		else $error("release marked as last result");

	// a released slot is no longer busy afterwards
	a_rel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rd_match |=> !bsts.busy[$past(rd_idx_s1)])
		else $error("released slot still busy");

endmodule
`default_nettype wire
